@@ hw/rtl/csle_pkg.sv @@
// Shared types and constants for the chunk size line encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package csle_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int SIZE_W      = 64;
    localparam int LIMIT_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int NIB_W       = 4;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [NIB_W-1:0]  sig_m1;
        logic [NIB_W-1:0]  cnt_m1;
    } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/csle_front.sv @@
// Front end: holds the digit limit register, accepts sizes and works out digit counts.
// Depends on csle_pkg.
`default_nettype none

module csle_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [csle_pkg::LIMIT_W-1:0]     cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [csle_pkg::SIZE_W-1:0]      size_value,
    output logic                                  job_valid,
    input  wire logic                             job_full,
    output csle_pkg::job_t                        job
);

    logic [csle_pkg::LIMIT_W-1:0] limit_reg;
    logic [csle_pkg::LIMIT_W-1:0] limit_next;
    logic                         valid_reg;
    logic                         valid_next;
    csle_pkg::job_t               job_reg;
    csle_pkg::job_t               job_next;
    logic                         accept;
    logic                         hand_off;
    logic [csle_pkg::NIB_W-1:0]   sig_m1;
    logic [csle_pkg::NIB_W-1:0]   lim_m1;

    assign hand_off = valid_reg && !job_full;
    assign full     = valid_reg && job_full;
    assign accept   = push && !full;

    always_comb
    begin
        sig_m1 = '0;
        for (int k = 1; k < csle_pkg::MAX_DIGITS; k++)
        begin
            if (size_value[k*csle_pkg::NIB_W +: csle_pkg::NIB_W] != '0)
            begin
                sig_m1 = csle_pkg::NIB_W'(k);
            end
        end
    end

    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_m1 = '0;
        end
        else if (limit_reg > csle_pkg::LIMIT_W'(csle_pkg::MAX_DIGITS))
        begin
            lim_m1 = csle_pkg::NIB_W'(csle_pkg::MAX_DIGITS - 1);
        end
        else
        begin
            lim_m1 = csle_pkg::NIB_W'(limit_reg - 1'b1);
        end
    end

    always_comb
    begin
        limit_next      = cfg_write ? cfg_data : limit_reg;
        job_next        = job_reg;
        job_next.size   = size_value;
        job_next.sig_m1 = sig_m1;
        job_next.cnt_m1 = (sig_m1 < lim_m1) ? sig_m1 : lim_m1;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (hand_off)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= csle_pkg::LIMIT_W'(csle_pkg::MAX_DIGITS);
            valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg <= limit_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

@@ hw/rtl/csle_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on csle_pkg.
`default_nettype none

module csle_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire csle_pkg::job_t wr_job,
    output logic                q_full,
    input  wire logic           rd_en,
    output logic                q_valid,
    output csle_pkg::job_t      rd_job
);

    localparam int PTR_W = (csle_pkg::QUEUE_DEPTH > 1) ? $clog2(csle_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(csle_pkg::QUEUE_DEPTH + 1);

    csle_pkg::job_t     slot_reg [csle_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (cnt_reg == CNT_W'(csle_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_job  = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(csle_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_wr ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/csle_back.sv @@
// Back end: sequences the hex digits, CR and LF of each job into the output register.
// Depends on csle_pkg.
`default_nettype none

module csle_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire csle_pkg::job_t                head,
    output logic                               q_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [csle_pkg::CHAR_W-1:0]        character,
    output logic                               last_char
);

    localparam logic [csle_pkg::CHAR_W-1:0] CHAR_CR = 8'd13;
    localparam logic [csle_pkg::CHAR_W-1:0] CHAR_LF = 8'd10;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIGIT = 4'b0010,
        S_CR    = 4'b0100,
        S_LF    = 4'b1000
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [csle_pkg::SIZE_W-1:0]        size_reg;
    logic [csle_pkg::SIZE_W-1:0]        size_next;
    logic [csle_pkg::NIB_W-1:0]         pos_reg;
    logic [csle_pkg::NIB_W-1:0]         pos_next;
    logic [csle_pkg::NIB_W-1:0]         rem_reg;
    logic [csle_pkg::NIB_W-1:0]         rem_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [csle_pkg::CHAR_W-1:0]        char_reg;
    logic [csle_pkg::CHAR_W-1:0]        char_next;
    logic                               last_reg;
    logic                               last_next;
    logic                               advance;
    logic                               emit;

    function automatic logic [csle_pkg::CHAR_W-1:0] hex_char(
        input logic [csle_pkg::SIZE_W-1:0] value,
        input logic [csle_pkg::NIB_W-1:0]  pos
    );
        logic [csle_pkg::NIB_W-1:0] nib;
        nib = value[{pos, 2'b00} +: csle_pkg::NIB_W];
        if (nib < 4'd10)
        begin
            return 8'd48 + csle_pkg::CHAR_W'(nib);
        end
        return 8'd55 + csle_pkg::CHAR_W'(nib);
    endfunction

    assign advance = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        char_next  = char_reg;
        last_next  = 1'b0;
        emit       = 1'b0;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && advance)
                begin
                    emit      = 1'b1;
                    q_pop     = 1'b1;
                    char_next = hex_char(head.size, head.sig_m1);
                    size_next = head.size;
                    pos_next  = head.sig_m1 - 1'b1;
                    rem_next  = head.cnt_m1;
                    state_next = (head.cnt_m1 == '0) ? S_CR : S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (advance)
                begin
                    emit      = 1'b1;
                    char_next = hex_char(size_reg, pos_reg);
                    pos_next  = pos_reg - 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    if (rem_reg == 4'd1)
                    begin
                        state_next = S_CR;
                    end
                end
            end
            S_CR:
            begin
                if (advance)
                begin
                    emit       = 1'b1;
                    char_next  = CHAR_CR;
                    state_next = S_LF;
                end
            end
            S_LF:
            begin
                if (advance)
                begin
                    emit       = 1'b1;
                    char_next  = CHAR_LF;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = advance ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        pos_reg  <= pos_next;
        rem_reg  <= rem_next;
        if (emit)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chunk_size_line_encoder.sv @@
// A taken size is registered in the front end and written into the job queue; its first byte
// is then loaded into the output register of the back end. Throughput: one output byte per
// cycle while pop is held, set by that single byte-wide register; a line is its digits, CR, LF.
// Sizes are taken in back to back while the two-entry job queue has room.
// Reset clears all control state and sets the digit limit to 16; no clearing pass is needed.
// Top level of the chunk size line encoder; depends on csle_pkg and its submodules.
`default_nettype none

module chunk_size_line_encoder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [csle_pkg::LIMIT_W-1:0]        cfg_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [csle_pkg::SIZE_W-1:0]         size_value,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [csle_pkg::CHAR_W-1:0]              character,
    output logic                                     last_char
);

    logic           job_valid;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    csle_pkg::job_t front_job;
    csle_pkg::job_t head_job;

    csle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .size_value (size_value),
        .job_valid  (job_valid),
        .job_full   (q_full),
        .job        (front_job)
    );

    csle_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_job  (front_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_job  (head_job)
    );

    csle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head_job),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last_char (last_char)
    );

endmodule

`default_nettype wire

@@ tb/chunk_size_line_encoder_test.sv @@
// Self-checking testbench for chunk_size_line_encoder: random and directed sizes, predicted lines.
// Predicts each hex size line in the bench and checks every output byte against it.
// Depends on csle_pkg and the chunk_size_line_encoder RTL.
`default_nettype none

module chunk_size_line_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [csle_pkg::CHAR_W-1:0] ASCII_CR   = 8'd13;
    localparam logic [csle_pkg::CHAR_W-1:0] ASCII_LF   = 8'd10;
    localparam logic [csle_pkg::CHAR_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [csle_pkg::CHAR_W-1:0] ASCII_A    = 8'd65;
    localparam int IDLE_PERCENT  = 34;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 23;

    typedef struct packed {
        logic [csle_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } line_byte_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [csle_pkg::LIMIT_W-1:0]   cfg_data = '0;
    logic                           push = 1'b0;
    logic                           full;
    logic [csle_pkg::SIZE_W-1:0]    size_value = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [csle_pkg::CHAR_W-1:0]    character;
    logic                           last_char;

    logic [csle_pkg::SIZE_W-1:0]    pending_sizes[$];
    line_byte_t                     expected_line_bytes[$];
    logic [csle_pkg::LIMIT_W-1:0]   digit_limit_copy = 5'd16;
    bit                             steady = 1'b0;
    int                             error_count = 0;
    int                             stall_cycles = 0;

    chunk_size_line_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .size_value (size_value),
        .empty      (empty),
        .pop        (pop),
        .character  (character),
        .last_char  (last_char)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    task automatic predict_size_line(input logic [csle_pkg::SIZE_W-1:0] sz);
        int sig;
        int limit;
        int count;
        logic [csle_pkg::NIB_W-1:0] nib;
        line_byte_t b;
        sig = 1;
        for (int k = 1; k < 16; k++)
        begin
            if ((sz >> (4 * k)) != 0)
                sig = k + 1;
        end
        limit = int'(digit_limit_copy);
        if (limit < 1)
            limit = 1;
        if (limit > csle_pkg::MAX_DIGITS)
            limit = csle_pkg::MAX_DIGITS;
        count = (sig < limit) ? sig : limit;
        for (int k = 0; k < count; k++)
        begin
            nib = sz[4 * (sig - 1 - k) +: 4];
            b.ch = (nib < 10) ? ASCII_ZERO + csle_pkg::CHAR_W'(nib)
                              : ASCII_A + csle_pkg::CHAR_W'(nib) - 8'd10;
            b.last = 1'b0;
            expected_line_bytes.push_back(b);
        end
        b.ch = ASCII_CR;
        b.last = 1'b0;
        expected_line_bytes.push_back(b);
        b.ch = ASCII_LF;
        b.last = 1'b1;
        expected_line_bytes.push_back(b);
    endtask

    function automatic logic [csle_pkg::SIZE_W-1:0] random_size();
        logic [csle_pkg::SIZE_W-1:0] v;
        int pick;
        int digits;
        v = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        if (pick < 20)
            return v;
        if (pick < 32)
            return v | (csle_pkg::SIZE_W'(1) << $urandom_range(61, 63));
        digits = $urandom_range(1, 16);
        v = v >> (4 * (16 - digits));
        v[4 * (digits - 1) +: 4] = 4'($urandom_range(1, 15));
        return v;
    endfunction

    // Sender: holds a transaction while full is high, predicts the line when it is taken.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_size_line(size_value);
            void'(pending_sizes.pop_front());
        end
        if (!rst_n)
            push <= 1'b0;
        else if (push && full)
            push <= 1'b1;
        else if (pending_sizes.size() != 0 && !take_break())
        begin
            push <= 1'b1;
            size_value <= pending_sizes[0];
        end
        else
            push <= 1'b0;
    end

    // Receiver: checks each popped transaction against the oldest predicted byte.
    always @(posedge clk)
    begin
        line_byte_t exp_b;
        if (rst_n && pop && !empty)
        begin
            if (expected_line_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual character %h last %b",
                         $time, character, last_char);
                error_count++;
            end
            else
            begin
                exp_b = expected_line_bytes.pop_front();
                if (character !== exp_b.ch)
                begin
                    $display("%0t: character mismatch, expected %h, actual %h",
                             $time, exp_b.ch, character);
                    error_count++;
                end
                if (last_char !== exp_b.last)
                begin
                    $display("%0t: last_char mismatch, expected %b, actual %b",
                             $time, exp_b.last, last_char);
                    error_count++;
                end
            end
        end
        pop <= rst_n && !take_break();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_for_idle();
        do
            @(posedge clk);
        while (pending_sizes.size() != 0 || expected_line_bytes.size() != 0 || push);
    endtask

    task automatic write_digit_limit(input logic [csle_pkg::LIMIT_W-1:0] value);
        wait_for_idle();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_data <= csle_pkg::LIMIT_W'($urandom);
        digit_limit_copy = value;
    endtask

    initial
    begin
        logic [csle_pkg::LIMIT_W-1:0] phase_limits[RANDOM_PHASES];
        phase_limits = '{5'd31, 5'd0, 5'd1, 5'd17, 5'd5, 5'd16, 5'd12, 5'd2,
                         csle_pkg::LIMIT_W'($urandom_range(1, 16))};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_sizes.push_back(64'h0);
        pending_sizes.push_back(64'h1);
        pending_sizes.push_back(64'h9);
        pending_sizes.push_back(64'hA);
        pending_sizes.push_back(64'hF);
        pending_sizes.push_back(64'h10);
        pending_sizes.push_back(64'hFF);
        pending_sizes.push_back(64'h0123_4567_89AB_CDEF);
        pending_sizes.push_back(64'hFEDC_BA98_7654_3210);
        pending_sizes.push_back(64'h1000_0000_0000_0000);
        pending_sizes.push_back(64'h1FFF_FFFF_FFFF_FFFF);
        pending_sizes.push_back(64'h2000_0000_0000_0000);
        pending_sizes.push_back(64'h8000_0000_0000_0000);
        pending_sizes.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_sizes.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_sizes.push_back(64'h5555_5555_5555_5555);
        pending_sizes.push_back(64'h0000_0001_0000_0000);
        pending_sizes.push_back(64'h0FFF_FFFF_FFFF_FFFF);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_digit_limit(phase_limits[p]);
            steady = (p == 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_sizes.push_back(random_size());
        end

        wait_for_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/csle_pkg.sv
hw/rtl/csle_front.sv
hw/rtl/csle_queue.sv
hw/rtl/csle_back.sv
hw/rtl/chunk_size_line_encoder.sv
tb/chunk_size_line_encoder_test.sv
